FILE: src/frpq_pkg.sv
// Shared types and constants of the framed packet receiver queue.
`default_nettype none
package frpq_pkg;

	localparam int QUEUE_SLOTS  = 8;
	localparam int PACKET_BYTES = 32;
	localparam int MAX_OUT      = 32;
	localparam int CMD_DEPTH    = 2;

	localparam int SLOT_W   = $clog2(QUEUE_SLOTS);
	localparam int CNT_W    = $clog2(QUEUE_SLOTS + 1);
	localparam int MEM_AW   = $clog2(QUEUE_SLOTS * PACKET_BYTES);
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 5;
	localparam int CPTR_W   = $clog2(CMD_DEPTH);
	localparam int CCNT_W   = $clog2(CMD_DEPTH + 1);

	localparam logic [7:0] HDR_SOH = 8'h01;
	localparam logic [7:0] HDR_STX = 8'h02;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_TICK = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_LEN     = 2'd1,
		PH_COLLECT = 2'd2,
		PH_DISCARD = 2'd3
	} rx_phase_t;

	typedef enum logic [2:0] {
		ST_QUEUED     = 3'd0,
		ST_BAD_SUM    = 3'd1,
		ST_BAD_LEN    = 3'd2,
		ST_DROPPED    = 3'd3,
		ST_READ_BYTE  = 3'd4,
		ST_READ_EMPTY = 3'd5
	} status_t;

	// Work handed from the front end to the back end.
	typedef struct packed {
		logic              is_read;
		status_t           status;
		logic [LEN_W-1:0]  plen;
		logic              ready;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

endpackage
`default_nettype wire

FILE: src/frpq_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module frpq_cmd_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire frpq_pkg::cmd_t wr_data,
	output logic                full,
	input  wire logic           rd_en,
	output frpq_pkg::cmd_t      rd_data,
	output logic                empty
);
	import frpq_pkg::*;

	cmd_t              mem_q [CMD_DEPTH];
	logic [CPTR_W-1:0] wr_ptr_q;
	logic [CPTR_W-1:0] rd_ptr_q;
	logic [CCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CCNT_W'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/frpq_front.sv
// Front end: frame hunting, checksum, slot ring bookkeeping and command issue.
`default_nettype none
module frpq_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [1:0]      kind,
	input  wire logic [7:0]      rx_byte,
	output frpq_pkg::cmd_t       cmd,
	output logic                 cmd_push,
	input  wire logic            cmd_full,
	input  wire logic            read_done,
	output frpq_pkg::mem_wr_t    mem_wr
);
	import frpq_pkg::*;

	rx_phase_t         phase_q, phase_d;
	logic [7:0]        prev_q, prev_d;
	logic [LEN_W-1:0]  flen_q, flen_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic [7:0]        sum_q, sum_d;
	logic [SLOT_W-1:0] wslot_q, wslot_d;
	logic [SLOT_W-1:0] rslot_q, rslot_d;
	logic [CNT_W-1:0]  queued_q, queued_d;
	logic [CNT_W-1:0]  reads_out_q, reads_out_d;
	logic [LEN_W-1:0]  slot_len_q [QUEUE_SLOTS];
	logic              slot_len_we;
	logic [CNT_W:0]    occupied;
	logic              stall;
	logic              accept;
	logic              read_issue;
	logic [LEN_W-1:0]  count_inc;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	// Slots still being streamed out are not free for writing yet.
	assign occupied  = {1'b0, queued_q} + {1'b0, reads_out_q};
	assign stall     = (kind == KIND_BYTE) && (phase_q == PH_COLLECT) &&
	                   (occupied >= (CNT_W + 1)'(QUEUE_SLOTS));
	assign full      = cmd_full || stall;
	assign accept    = push && !full;
	assign count_inc = count_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		prev_d      = prev_q;
		flen_d      = flen_q;
		count_d     = count_q;
		sum_d       = sum_q;
		wslot_d     = wslot_q;
		rslot_d     = rslot_q;
		queued_d    = queued_q;
		slot_len_we = 1'b0;
		read_issue  = 1'b0;
		cmd_push    = 1'b0;
		cmd         = '0;
		mem_wr.en   = 1'b0;
		mem_wr.addr = MEM_AW'(wslot_q) * MEM_AW'(PACKET_BYTES) + MEM_AW'(count_q);
		mem_wr.data = rx_byte;
		if (accept) begin
			unique case (kind)
				KIND_BYTE: begin
					unique case (phase_q)
						PH_HUNT: begin
							if (prev_q == HDR_SOH && rx_byte == HDR_STX) begin
								phase_d = PH_LEN;
								prev_d  = '0;
							end else begin
								prev_d = rx_byte;
							end
						end
						PH_LEN: begin
							if (rx_byte == '0 || rx_byte > 8'(PACKET_BYTES)) begin
								phase_d    = PH_HUNT;
								prev_d     = '0;
								count_d    = '0;
								sum_d      = '0;
								cmd_push   = 1'b1;
								cmd.status = ST_BAD_LEN;
								cmd.ready  = (queued_q != '0);
							end else begin
								flen_d  = rx_byte[LEN_W-1:0];
								count_d = '0;
								sum_d   = '0;
								phase_d = (queued_q >= CNT_W'(QUEUE_SLOTS)) ?
								          PH_DISCARD : PH_COLLECT;
							end
						end
						PH_COLLECT, PH_DISCARD: begin
							mem_wr.en = (phase_q == PH_COLLECT);
							count_d   = count_inc;
							if (count_inc < flen_q) begin
								sum_d = sum_q + rx_byte;
							end else begin
								// Frame complete: the last byte is the checksum.
								cmd_push = 1'b1;
								cmd.plen = flen_q;
								if (phase_q == PH_DISCARD) begin
									cmd.status = ST_DROPPED;
								end else if (rx_byte == sum_q) begin
									cmd.status  = ST_QUEUED;
									slot_len_we = 1'b1;
									wslot_d     = next_slot(wslot_q);
									queued_d    = queued_q + 1'b1;
								end else begin
									cmd.status = ST_BAD_SUM;
								end
								cmd.ready = (queued_d != '0);
								phase_d   = PH_HUNT;
								prev_d    = '0;
								count_d   = '0;
								sum_d     = '0;
							end
						end
					endcase
				end
				KIND_TICK: begin
					if (phase_q == PH_HUNT) begin
						prev_d = '0;
					end else begin
						cmd_push   = 1'b1;
						cmd.status = ST_BAD_LEN;
						cmd.plen   = (phase_q == PH_LEN) ? '0 : flen_q;
						cmd.ready  = (queued_q != '0);
						phase_d    = PH_HUNT;
						prev_d     = '0;
						count_d    = '0;
						sum_d      = '0;
					end
				end
				KIND_READ: begin
					cmd_push = 1'b1;
					if (queued_q == '0) begin
						cmd.status = ST_READ_EMPTY;
					end else begin
						read_issue  = 1'b1;
						cmd.is_read = 1'b1;
						cmd.status  = ST_READ_BYTE;
						cmd.plen    = slot_len_q[rslot_q];
						cmd.slot    = rslot_q;
						rslot_d     = next_slot(rslot_q);
						queued_d    = queued_q - 1'b1;
						cmd.ready   = (queued_d != '0);
					end
				end
				default: begin
					// drop the reserved kind
				end
			endcase
		end
	end

	always_comb begin
		reads_out_d = reads_out_q;
		if (read_issue && !read_done) begin
			reads_out_d = reads_out_q + 1'b1;
		end else if (read_done && !read_issue) begin
			reads_out_d = reads_out_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_len_we) begin
			slot_len_q[wslot_q] <= flen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			prev_q      <= '0;
			flen_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			wslot_q     <= '0;
			rslot_q     <= '0;
			queued_q    <= '0;
			reads_out_q <= '0;
		end else begin
			phase_q     <= phase_d;
			prev_q      <= prev_d;
			flen_q      <= flen_d;
			count_q     <= count_d;
			sum_q       <= sum_d;
			wslot_q     <= wslot_d;
			rslot_q     <= rslot_d;
			queued_q    <= queued_d;
			reads_out_q <= reads_out_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/frpq_back.sv
// Back end: packet byte store, read-out streaming and the result register.
`default_nettype none
module frpq_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire frpq_pkg::cmd_t     cmd,
	input  wire logic               cmd_empty,
	output logic                    cmd_pop,
	input  wire frpq_pkg::mem_wr_t  mem_wr,
	output logic                    read_done,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              status,
	output logic [7:0]              data_byte,
	output logic [4:0]              byte_index,
	output logic [5:0]              packet_length,
	output logic                    last,
	output logic                    ready_res
);
	import frpq_pkg::*;

	logic [7:0]        mem_q [QUEUE_SLOTS * PACKET_BYTES];

	logic              stream_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  len_q;
	logic [SLOT_W-1:0] slot_q;
	logic              rdy_q;

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              last_s1;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [7:0]        out_data_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;
	logic              out_rdy_q;

	logic              can_out;
	logic              s1_move;
	logic              issue;
	logic              issue_last;
	logic [LEN_W-1:0]  k_inc;
	logic [LEN_W-1:0]  cmd_n;
	logic [MEM_AW-1:0] rd_addr;

	assign empty         = !out_valid_q;
	assign status        = out_status_q;
	assign data_byte     = out_data_q;
	assign byte_index    = out_idx_q;
	assign packet_length = out_len_q;
	assign last          = out_last_q;
	assign ready_res     = out_rdy_q;

	assign can_out    = !out_valid_q || pop;
	assign s1_move    = valid_s1 && can_out;
	assign issue      = stream_q && (!valid_s1 || s1_move);
	assign k_inc      = k_q + 1'b1;
	assign issue_last = (k_inc == n_q);
	assign read_done  = issue && issue_last;
	assign rd_addr    = MEM_AW'(slot_q) * MEM_AW'(PACKET_BYTES) + MEM_AW'(k_q);

	// Take a new command only once the previous read-out has drained.
	assign cmd_pop = !cmd_empty && !stream_q && !valid_s1 && (cmd.is_read || can_out);
	assign cmd_n   = (cmd.plen > LEN_W'(MAX_OUT)) ? LEN_W'(MAX_OUT) :
	                 (cmd.plen == '0) ? LEN_W'(1) : cmd.plen;

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			data_s1 <= mem_q[rd_addr];
			idx_s1  <= k_q[IDX_W-1:0];
			last_s1 <= issue_last;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_status_q <= ST_READ_BYTE;
			out_data_q   <= data_s1;
			out_idx_q    <= idx_s1;
			out_len_q    <= len_q;
			out_last_q   <= last_s1;
			out_rdy_q    <= rdy_q;
		end else if (cmd_pop && !cmd.is_read) begin
			out_status_q <= cmd.status;
			out_data_q   <= '0;
			out_idx_q    <= '0;
			out_len_q    <= cmd.plen;
			out_last_q   <= 1'b1;
			out_rdy_q    <= cmd.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.is_read) begin
			n_q    <= cmd_n;
			len_q  <= cmd.plen;
			slot_q <= cmd.slot;
			rdy_q  <= cmd.ready;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_q    <= 1'b0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop && cmd.is_read) begin
				stream_q <= 1'b1;
				k_q      <= '0;
			end else if (issue) begin
				k_q <= k_inc;
				if (issue_last) begin
					stream_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move || (cmd_pop && !cmd.is_read)) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/framed_packet_receiver_queue.sv
// Framed packet receiver: header hunt, length and checksum check, slot ring, read-out.
// Input channel (push/full): each transaction carries kind and rx_byte. Kind 0
// is a received byte, kind 1 a receive timeout tick, kind 2 a request to read
// the oldest stored packet; kind 3 is ignored.
// Result channel (empty/pop): each transaction carries status, data_byte,
// byte_index, packet_length, last and ready_res. A frame end, a bad length, an
// abort or an empty read gives one result; a read gives one result per stored
// byte, checksum byte last, with last set on the final one.
// Timing: a result passes the command queue and then the result register. A read-out
// stream passes the command queue, address counter, registered read port of the packet
// store and result register; it runs one byte per cycle while results are popped.
// Throughput: one input transaction per cycle while the two-entry command
// queue has room; a received byte inside a frame also waits while its target
// slot is still being streamed out.
// Reset: the receiver returns to header hunting and the slot ring is emptied.
// Stalls: when pop is held low the result register holds, the command queue
// fills and full is raised; nothing is lost.
`default_nettype none
module framed_packet_receiver_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] rx_byte,
	output logic            empty,
	input  wire logic       pop,
	output logic [2:0]      status,
	output logic [7:0]      data_byte,
	output logic [4:0]      byte_index,
	output logic [5:0]      packet_length,
	output logic            last,
	output logic            ready_res
);
	import frpq_pkg::*;

	cmd_t    front_cmd;
	logic    front_cmd_push;
	cmd_t    back_cmd;
	logic    cmd_full;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    read_done;
	mem_wr_t mem_wr;

	frpq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.cmd       (front_cmd),
		.cmd_push  (front_cmd_push),
		.cmd_full  (cmd_full),
		.read_done (read_done),
		.mem_wr    (mem_wr)
	);

	frpq_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_cmd_push),
		.wr_data (front_cmd),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (back_cmd),
		.empty   (cmd_empty)
	);

	frpq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (back_cmd),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.mem_wr        (mem_wr),
		.read_done     (read_done),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.data_byte     (data_byte),
		.byte_index    (byte_index),
		.packet_length (packet_length),
		.last          (last),
		.ready_res     (ready_res)
	);

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the framed packet receiver queue: directed and random traffic.
`timescale 1ns / 100ps
module tb;
	import frpq_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int ITEM_TARGET = 470;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_AT     = 60;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 20;
	localparam int N_DIRECTED  = 30;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [5:0] gap;
		logic       drain;
	} link_item_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data;
		logic [IDX_W-1:0] index;
		logic [LEN_W-1:0] plen;
		logic             last;
		logic             ready;
	} frame_result_t;

	// kind and byte of each directed transaction
	localparam logic [9:0] DIRECTED [N_DIRECTED] = '{
		{KIND_READ, 8'h00}, {KIND_SPARE, 8'hff},
		{KIND_BYTE, HDR_SOH}, {KIND_TICK, 8'ha5}, {KIND_BYTE, HDR_STX},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_TICK, 8'h00},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_BYTE, 8'h00},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_BYTE, 8'h21},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_BYTE, 8'h01}, {KIND_BYTE, 8'h00},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_BYTE, 8'h02},
		{KIND_BYTE, 8'hff}, {KIND_BYTE, 8'hff},
		{KIND_BYTE, HDR_SOH}, {KIND_BYTE, HDR_STX}, {KIND_BYTE, 8'h04},
		{KIND_BYTE, 8'h11}, {KIND_TICK, 8'h00},
		{KIND_READ, 8'h00}, {KIND_READ, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] kind = KIND_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] status;
	logic [7:0] data_byte;
	logic [4:0] byte_index;
	logic [5:0] packet_length;
	logic       last;
	logic       ready_res;

	framed_packet_receiver_queue dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .kind(kind), .rx_byte(rx_byte),
		.empty(empty), .pop(pop),
		.status(status), .data_byte(data_byte), .byte_index(byte_index),
		.packet_length(packet_length), .last(last), .ready_res(ready_res)
	);

	always #5 clk = ~clk;

	link_item_t    link_items[$];
	frame_result_t pending_results[$];
	int            item_count = 0;
	int            mismatches = 0;
	int            stall_cycles = 0;

	// deframer state
	logic [7:0]        rx_prev;
	rx_phase_t         rx_state;
	logic [7:0]        frame_len;
	logic [7:0]        frame_count;
	logic [7:0]        frame_sum;
	logic [7:0]        slot_mem [QUEUE_SLOTS][PACKET_BYTES];
	logic [LEN_W-1:0]  slot_len [QUEUE_SLOTS];
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] rd_slot;
	logic [CNT_W-1:0]  slots_used;

	function automatic logic [5:0] pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			return 6'd0;
		if (r < 92)
			return 6'($urandom_range(1, 3));
		return 6'($urandom_range(10, 40));
	endfunction

	function automatic int pick_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, PACKET_BYTES - 1);
		return PACKET_BYTES;
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (int'(s) == QUEUE_SLOTS - 1) ? '0 : s + 1'b1;
	endfunction

	task automatic emit_result(input status_t st, input logic [7:0] d,
			input logic [IDX_W-1:0] i, input logic [LEN_W-1:0] pl, input logic lst);
		pending_results.push_back('{st, d, i, pl, lst, slots_used != 0});
	endtask

	task automatic restart_hunt();
		rx_state = PH_HUNT;
		rx_prev = 8'h00;
		frame_count = 8'h00;
		frame_sum = 8'h00;
	endtask

	task automatic deframe_item(input logic [1:0] k, input logic [7:0] b);
		status_t          st;
		logic [LEN_W-1:0] plen;
		logic [SLOT_W-1:0] slot;
		int               j;
		case (k)
			KIND_BYTE: begin
				case (rx_state)
					PH_HUNT: begin
						if (rx_prev == HDR_SOH && b == HDR_STX) begin
							rx_state = PH_LEN;
							rx_prev = 8'h00;
						end else begin
							rx_prev = b;
						end
					end
					PH_LEN: begin
						if (b == 8'h00 || b > PACKET_BYTES) begin
							restart_hunt();
							emit_result(ST_BAD_LEN, 8'h00, '0, '0, 1'b1);
						end else begin
							frame_len = b;
							frame_count = 8'h00;
							frame_sum = 8'h00;
							rx_state = (slots_used >= QUEUE_SLOTS) ? PH_DISCARD : PH_COLLECT;
						end
					end
					default: begin
						if (rx_state == PH_COLLECT)
							slot_mem[wr_slot][frame_count] = b;
						if (frame_count + 1 < frame_len)
							frame_sum = frame_sum + b;
						frame_count = frame_count + 8'd1;
						if (frame_count >= frame_len) begin
							if (rx_state == PH_DISCARD) begin
								st = ST_DROPPED;
							end else if (b == frame_sum) begin
								st = ST_QUEUED;
								slot_len[wr_slot] = frame_len[LEN_W-1:0];
								wr_slot = next_slot(wr_slot);
								slots_used = slots_used + 1'b1;
							end else begin
								st = ST_BAD_SUM;
							end
							restart_hunt();
							emit_result(st, 8'h00, '0, frame_len[LEN_W-1:0], 1'b1);
						end
					end
				endcase
			end
			KIND_TICK: begin
				if (rx_state == PH_HUNT) begin
					rx_prev = 8'h00;
				end else begin
					plen = (rx_state == PH_LEN) ? '0 : frame_len[LEN_W-1:0];
					restart_hunt();
					emit_result(ST_BAD_LEN, 8'h00, '0, plen, 1'b1);
				end
			end
			KIND_READ: begin
				if (slots_used == 0) begin
					emit_result(ST_READ_EMPTY, 8'h00, '0, '0, 1'b1);
				end else begin
					slot = rd_slot;
					plen = slot_len[slot];
					rd_slot = next_slot(rd_slot);
					slots_used = slots_used - 1'b1;
					for (j = 0; j < int'(plen); j++)
						emit_result(ST_READ_BYTE, slot_mem[slot][j], IDX_W'(j), plen,
							j + 1 == int'(plen));
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_item(input logic [1:0] k, input logic [7:0] b, input logic drain);
		link_item_t it;
		it.kind = k;
		it.data = b;
		it.drain = drain;
		// hold a stretch with no sender gaps
		it.gap = (item_count >= 180 && item_count < 240) ? 6'd0 : pick_gap();
		link_items.push_back(it);
		if (k != KIND_SPARE)
			item_count++;
	endtask

	// cut: payload bytes sent before a timeout tick; cut >= len gives a complete frame
	task automatic queue_frame(input int len, input bit corrupt, input int cut,
			input logic drain);
		logic [7:0] sum;
		logic [7:0] b;
		int         j;
		queue_item(KIND_BYTE, HDR_SOH, drain);
		queue_item(KIND_BYTE, HDR_STX, 1'b0);
		queue_item(KIND_BYTE, 8'(len), 1'b0);
		sum = 8'h00;
		for (j = 0; j < len; j++) begin
			if (j == cut) begin
				queue_item(KIND_TICK, 8'h00, 1'b0);
				break;
			end
			if (j < len - 1) begin
				b = 8'($urandom_range(255));
				sum = sum + b;
			end else begin
				b = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
			end
			queue_item(KIND_BYTE, b, 1'b0);
		end
	endtask

	// driver
	logic       offer_next;
	link_item_t next_item;
	int         idle_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			kind <= KIND_BYTE;
			rx_byte <= 8'h00;
			idle_wait = 0;
			restart_hunt();
			frame_len = 8'h00;
			wr_slot = '0;
			rd_slot = '0;
			slots_used = '0;
		end else begin
			if (push && !full)
				deframe_item(kind, rx_byte);
			if (!push || !full) begin
				offer_next = 1'b0;
				if (link_items.size() != 0) begin
					if (idle_wait < int'(link_items[0].gap)) begin
						idle_wait++;
					end else if (!link_items[0].drain || pending_results.size() == 0) begin
						next_item = link_items.pop_front();
						offer_next = 1'b1;
						idle_wait = 0;
					end
				end
				push <= offer_next;
				if (offer_next) begin
					kind <= next_item.kind;
					rx_byte <= next_item.data;
				end
			end
		end
	end

	// monitor
	frame_result_t want_result;
	int            hold_left;
	int            results_taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			hold_left = 0;
			results_taken = 0;
		end else begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, status %0d",
						status));
				end else begin
					want_result = pending_results.pop_front();
					if (status != want_result.status)
						report_mismatch($sformatf("status: got %0d, expected %0d",
							status, want_result.status));
					if (data_byte != want_result.data)
						report_mismatch($sformatf("data_byte: got %0d, expected %0d",
							data_byte, want_result.data));
					if (byte_index != want_result.index)
						report_mismatch($sformatf("byte_index: got %0d, expected %0d",
							byte_index, want_result.index));
					if (packet_length != want_result.plen)
						report_mismatch($sformatf("packet_length: got %0d, expected %0d",
							packet_length, want_result.plen));
					if (last != want_result.last)
						report_mismatch($sformatf("last: got %0d, expected %0d",
							last, want_result.last));
					if (ready_res != want_result.ready)
						report_mismatch($sformatf("ready_res: got %0d, expected %0d",
							ready_res, want_result.ready));
				end
				results_taken++;
				// hold off long enough for the input side to back up
				if (results_taken == HOLD_AT)
					hold_left = HOLD_CYCLES;
				else if (results_taken >= 400 && results_taken < 520)
					hold_left = 0;
				else
					hold_left = pick_gap();
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// only progress that is expected keeps the run alive
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((push && !full) || (pop && !empty && pending_results.size() != 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int   j;
		int   len;
		int   roll;
		bit   burst_done;
		logic timed_out;
		burst_done = 1'b0;
		timed_out = 1'b0;
		for (j = 0; j < N_DIRECTED; j++)
			queue_item(DIRECTED[j][9:8], DIRECTED[j][7:0], 1'b0);
		// pause the sender until the directed results have drained
		len = pick_len();
		queue_frame(len, 1'b0, len, 1'b1);
		while (item_count < ITEM_TARGET) begin
			if (!burst_done && item_count >= 250) begin
				// fill every slot, overflow it, then read back past empty
				burst_done = 1'b1;
				for (j = 0; j < 10; j++) begin
					len = (j == 4) ? PACKET_BYTES : pick_len();
					queue_frame(len, 1'b0, len, j == 0);
				end
				for (j = 0; j < 10; j++)
					queue_item(KIND_READ, 8'h00, 1'b0);
			end
			roll = $urandom_range(99);
			len = pick_len();
			if (roll < 38) begin
				queue_frame(len, 1'b0, len, 1'b0);
			end else if (roll < 46) begin
				queue_frame(len, 1'b1, len, 1'b0);
			end else if (roll < 51) begin
				queue_item(KIND_BYTE, HDR_SOH, 1'b0);
				queue_item(KIND_BYTE, HDR_STX, 1'b0);
				queue_item(KIND_BYTE, ($urandom_range(1) != 0) ? 8'h00 :
					8'($urandom_range(PACKET_BYTES + 1, 255)), 1'b0);
			end else if (roll < 57) begin
				if ($urandom_range(3) == 0) begin
					queue_item(KIND_BYTE, HDR_SOH, 1'b0);
					queue_item(KIND_BYTE, HDR_STX, 1'b0);
					queue_item(KIND_TICK, 8'($urandom_range(255)), 1'b0);
				end else begin
					queue_frame(len, 1'b0, $urandom_range(0, len - 1), 1'b0);
				end
			end else if (roll < 64) begin
				// line noise, then a tick to drop any frame it opened
				repeat ($urandom_range(1, 4))
					queue_item(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
				queue_item(KIND_TICK, 8'h00, 1'b0);
			end else if (roll < 92) begin
				queue_item(KIND_READ, 8'($urandom_range(255)), 1'b0);
			end else if (roll < 97) begin
				queue_item(KIND_TICK, 8'($urandom_range(255)), 1'b0);
			end else begin
				queue_item(KIND_SPARE, 8'($urandom_range(255)), 1'b0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (link_items.size() != 0 || push || pending_results.size() != 0))
		begin
			@(posedge clk);
			timed_out = stall_cycles >= STALL_LIMIT;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(posedge clk);
		if (timed_out || mismatches != 0)
			$display("end of test: mismatches");
		else
			$display("end of test: clean");
		$finish;
	end

endmodule

FILE: framed_packet_receiver_queue.f
src/frpq_pkg.sv
src/frpq_cmd_fifo.sv
src/frpq_front.sv
src/frpq_back.sv
src/framed_packet_receiver_queue.sv
bench/tb.sv
